// ===== sv/ouart_pkg.sv =====
// Shared types and constants for the oversampled UART.
package ouart_pkg;

    localparam int FIFO_DEPTH_DEF = 32;
    localparam int TICKS_PER_BIT  = 3;
    localparam int FIRST_SAMPLE   = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int FRAME_BITS_W = 4;
    localparam int FILL_W = 5;

    localparam logic [7:0]              DROP_BYTE_RST     = 8'hC2;
    localparam logic [FRAME_BITS_W-1:0] RX_DATA_BITS_RST  = 4'd8;
    localparam logic [FRAME_BITS_W-1:0] TX_FRAME_BITS_RST = 4'd10;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_PUT  = 2'd1,
        OP_GET  = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RX_ENABLE     = 2'd0,
        CFG_RX_DATA_BITS  = 2'd1,
        CFG_TX_FRAME_BITS = 2'd2,
        CFG_DROP_BYTE     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                    rx_enable;
        logic [FRAME_BITS_W-1:0] rx_data_bits;
        logic [FRAME_BITS_W-1:0] tx_frame_bits;
        logic [7:0]              drop_byte;
    } cfg_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       rx_line;
        logic [7:0] put_data;
    } cmd_t;

    typedef struct packed {
        logic tx_line;
        logic tx_busy;
        logic put_accepted;
    } tx_stat_t;

    typedef struct packed {
        logic              get_valid;
        logic              rx_overflow;
        logic [FILL_W-1:0] fill_count;
    } rx_stat_t;

    typedef struct packed {
        logic              tx_line;
        logic              put_accepted;
        logic              get_valid;
        logic [7:0]        get_data;
        logic [FILL_W-1:0] fill_count;
        logic              tx_busy;
        logic              rx_overflow;
    } res_t;

endpackage

// ===== sv/ouart_cmd_if.sv =====
// Command channel: opcode, receive pin level and transmit byte.
interface ouart_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       rx_line;
    logic [7:0] put_data;

    modport source (output valid, output opcode, output rx_line, output put_data,
                    input ready);
    modport sink   (input valid, input opcode, input rx_line, input put_data,
                    output ready);
endinterface

// ===== sv/ouart_rsp_if.sv =====
// Result channel: one status item for every command item.
interface ouart_rsp_if;
    logic       valid;
    logic       ready;
    logic       tx_line;
    logic       put_accepted;
    logic       get_valid;
    logic [7:0] get_data;
    logic [4:0] fill_count;
    logic       tx_busy;
    logic       rx_overflow;

    modport source (output valid, output tx_line, output put_accepted, output get_valid,
                    output get_data, output fill_count, output tx_busy,
                    output rx_overflow, input ready);
    modport sink   (input valid, input tx_line, input put_accepted, input get_valid,
                    input get_data, input fill_count, input tx_busy,
                    input rx_overflow, output ready);
endinterface

// ===== sv/ouart_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface ouart_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/ouart_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ouart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== sv/ouart_tx.sv =====
// Transmitter: frame shift register, bit timing and put handling.
module ouart_tx
    import ouart_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  cmd_t     cmd,
    input  cfg_t     cfg,
    output tx_stat_t stat
);
    logic [9:0]              shift_reg, shift_next;
    logic [1:0]              tick_reg, tick_next;
    logic [FRAME_BITS_W-1:0] bits_reg, bits_next;
    logic                    active_reg, active_next;
    logic                    level_reg, level_next;
    logic                    accepted;

    always_comb
    begin
        shift_next  = shift_reg;
        tick_next   = tick_reg;
        bits_next   = bits_reg;
        active_next = active_reg;
        level_next  = level_reg;
        accepted    = 1'b0;
        if (fire && cmd.opcode == OP_TICK && active_reg)
        begin
            if (tick_reg <= 2'd1)
            begin
                level_next = shift_reg[0];
                shift_next = {1'b0, shift_reg[9:1]};
                tick_next  = 2'(TICKS_PER_BIT);
                if (bits_reg <= 4'd1)
                begin
                    bits_next   = '0;
                    active_next = 1'b0;
                end
                else
                begin
                    bits_next = bits_reg - 4'd1;
                end
            end
            else
            begin
                tick_next = tick_reg - 2'd1;
            end
        end
        else if (fire && cmd.opcode == OP_PUT && !active_reg)
        begin
            tick_next   = 2'(TICKS_PER_BIT);
            bits_next   = cfg.tx_frame_bits;
            shift_next  = {1'b1, cmd.put_data, 1'b0};
            active_next = 1'b1;
            accepted    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= '0;
            tick_reg   <= '0;
            bits_reg   <= '0;
            active_reg <= 1'b0;
            level_reg  <= 1'b1;
        end
        else
        begin
            shift_reg  <= shift_next;
            tick_reg   <= tick_next;
            bits_reg   <= bits_next;
            active_reg <= active_next;
            level_reg  <= level_next;
        end
    end

    assign stat.tx_line      = level_next;
    assign stat.tx_busy      = active_next;
    assign stat.put_accepted = accepted;
endmodule

// ===== sv/ouart_rx.sv =====
// Receiver: start detection, bit sampling and the receive FIFO held in RAM.
module ouart_rx
    import ouart_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  cmd_t       cmd,
    input  cfg_t       cfg,
    output rx_stat_t   stat,
    output logic [7:0] rd_data
);
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
    localparam logic [PW-1:0] PTR_ONE  = PW'(1);
    localparam logic [PW:0]   DEPTH_V  = (PW + 1)'(FIFO_DEPTH);

    logic                    active_reg, active_next;
    logic                    wait_reg, wait_next;
    logic [2:0]              tick_reg, tick_next;
    logic [FRAME_BITS_W-1:0] bits_reg, bits_next;
    logic [7:0]              shift_reg, shift_next;
    logic [7:0]              sel_reg, sel_next;
    logic [PW-1:0]           wp_reg, wp_next, wp_inc;
    logic [PW-1:0]           rp_reg, rp_next, rp_inc;
    logic                    wr_en, rd_en, lost;
    logic [PW:0]             diff, fill;

    assign wp_inc = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_ONE;
    assign rp_inc = (rp_reg == PTR_LAST) ? '0 : rp_reg + PTR_ONE;

    always_comb
    begin
        active_next = active_reg;
        wait_next   = wait_reg;
        tick_next   = tick_reg;
        bits_next   = bits_reg;
        shift_next  = shift_reg;
        sel_next    = sel_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        lost        = 1'b0;
        if (fire && cmd.opcode == OP_TICK && cfg.rx_enable)
        begin
            if (wait_reg)
            begin
                if (tick_reg <= 3'd1)
                begin
                    tick_next   = '0;
                    wait_next   = 1'b0;
                    active_next = 1'b0;
                    if (shift_reg != cfg.drop_byte)
                    begin
                        if (wp_inc == rp_reg)
                        begin
                            lost = 1'b1;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wp_next = wp_inc;
                        end
                    end
                end
                else
                begin
                    tick_next = tick_reg - 3'd1;
                end
            end
            else if (!active_reg)
            begin
                if (!cmd.rx_line)
                begin
                    active_next = 1'b1;
                    shift_next  = '0;
                    tick_next   = 3'(FIRST_SAMPLE);
                    bits_next   = cfg.rx_data_bits;
                    sel_next    = 8'd1;
                end
            end
            else if (tick_reg <= 3'd1)
            begin
                tick_next = 3'(TICKS_PER_BIT);
                if (cmd.rx_line)
                begin
                    shift_next = shift_reg | sel_reg;
                end
                sel_next = {sel_reg[6:0], 1'b0};
                if (bits_reg <= 4'd1)
                begin
                    bits_next = '0;
                    wait_next = 1'b1;
                end
                else
                begin
                    bits_next = bits_reg - 4'd1;
                end
            end
            else
            begin
                tick_next = tick_reg - 3'd1;
            end
        end
        else if (fire && cmd.opcode == OP_GET && rp_reg != wp_reg)
        begin
            rd_en   = 1'b1;
            rp_next = rp_inc;
        end
    end

    always_comb
    begin
        diff = {1'b0, wp_next} - {1'b0, rp_next};
        fill = diff[PW] ? diff + DEPTH_V : diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            wait_reg   <= 1'b0;
            tick_reg   <= '0;
            bits_reg   <= '0;
            shift_reg  <= '0;
            sel_reg    <= 8'd1;
            wp_reg     <= '0;
            rp_reg     <= '0;
        end
        else
        begin
            active_reg <= active_next;
            wait_reg   <= wait_next;
            tick_reg   <= tick_next;
            bits_reg   <= bits_next;
            shift_reg  <= shift_next;
            sel_reg    <= sel_next;
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
        end
    end

    ouart_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (shift_reg),
        .rd_en   (rd_en),
        .rd_addr (rp_reg),
        .rd_data (rd_data)
    );

    assign stat.get_valid   = rd_en;
    assign stat.rx_overflow = lost;
    assign stat.fill_count  = FILL_W'(fill);
endmodule

// ===== sv/oversampled_soft_uart.sv =====
// Top level of the oversampled UART: configuration, result pipeline and units.
//
// Each command item on cmd is a tick at three times the baud rate, a put of one
// byte to the transmitter, a get of one byte from the receive FIFO, or a no-op.
// Every command item yields exactly one result item on rsp, in order, carrying
// the transmit pin level, put and get outcomes, the FIFO fill and overflow.
// The receive FIFO sits in a RAM with a registered read port, so a get's byte
// arrives in the cycle after the command is taken; the result item therefore
// passes two registers, s1 and the output register, before it appears on rsp.
// One command item is accepted per cycle while rsp keeps up.
// When rsp stalls, one result waits in the output register and one more in
// the stage behind it; cmd.ready then drops until rsp takes an item.
// Configuration writes on cfg are always taken and should be made while the
// block is idle. After reset the transmit line is high, the FIFO is empty,
// the receiver is enabled for 8 data bits, frames are 10 bits and the drop
// byte is 0xC2. FIFO contents are not cleared, as only written entries are read.
module oversampled_soft_uart
    import ouart_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    ouart_cmd_if.sink   cmd,
    ouart_rsp_if.source rsp,
    ouart_cfg_if.sink   cfg
);
    cfg_t     cfg_reg;
    cmd_t     cmd_bus;
    tx_stat_t tx_stat;
    rx_stat_t rx_stat;
    logic [7:0] rd_data;

    logic cmd_fire, out_load;
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    res_t s1_reg, s1_next;
    res_t out_reg, out_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rx_enable     <= 1'b1;
            cfg_reg.rx_data_bits  <= RX_DATA_BITS_RST;
            cfg_reg.tx_frame_bits <= TX_FRAME_BITS_RST;
            cfg_reg.drop_byte     <= DROP_BYTE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_RX_ENABLE:     cfg_reg.rx_enable     <= cfg.data[0];
                CFG_RX_DATA_BITS:  cfg_reg.rx_data_bits  <= cfg.data[FRAME_BITS_W-1:0];
                CFG_TX_FRAME_BITS: cfg_reg.tx_frame_bits <= cfg.data[FRAME_BITS_W-1:0];
                CFG_DROP_BYTE:     cfg_reg.drop_byte     <= cfg.data;
                default:           ;
            endcase
        end
    end

    assign cmd_bus.opcode   = cmd.opcode;
    assign cmd_bus.rx_line  = cmd.rx_line;
    assign cmd_bus.put_data = cmd.put_data;

    assign out_load  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || out_load;
    assign cmd_fire  = cmd.valid && cmd.ready;

    ouart_tx u_tx (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (cmd_fire),
        .cmd   (cmd_bus),
        .cfg   (cfg_reg),
        .stat  (tx_stat)
    );

    ouart_rx #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (cmd_fire),
        .cmd     (cmd_bus),
        .cfg     (cfg_reg),
        .stat    (rx_stat),
        .rd_data (rd_data)
    );

    always_comb
    begin
        s1_next = s1_reg;
        if (cmd_fire)
        begin
            s1_next.tx_line      = tx_stat.tx_line;
            s1_next.put_accepted = tx_stat.put_accepted;
            s1_next.get_valid    = rx_stat.get_valid;
            s1_next.get_data     = '0;
            s1_next.fill_count   = rx_stat.fill_count;
            s1_next.tx_busy      = tx_stat.tx_busy;
            s1_next.rx_overflow  = rx_stat.rx_overflow;
        end
        out_next = out_reg;
        if (out_load)
        begin
            out_next          = s1_reg;
            out_next.get_data = s1_reg.get_valid ? rd_data : 8'd0;
        end
        s1_valid_next  = cmd_fire || (s1_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.tx_line      = out_reg.tx_line;
    assign rsp.put_accepted = out_reg.put_accepted;
    assign rsp.get_valid    = out_reg.get_valid;
    assign rsp.get_data     = out_reg.get_data;
    assign rsp.fill_count   = out_reg.fill_count;
    assign rsp.tx_busy      = out_reg.tx_busy;
    assign rsp.rx_overflow  = out_reg.rx_overflow;
endmodule
